FILE: hdl/srpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srpl_pkg;

  localparam int unsigned HoldBits    = 16;
  localparam logic [15:0] HoldReset   = 16'd255;
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned CfgDataBits = 32;

  typedef enum logic [0:0] {
    REG_HOLD_RELOAD = 1'b0,
    REG_UNUSED      = 1'b1
  } srpl_reg_t;

  typedef struct packed {
    logic start;
    logic square;
    logic accum;
    logic root_init;
    logic root_step;
    logic peak;
    logic load_out;
  } srpl_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/srpl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srpl_in_if #(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface srpl_out_if #(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_level;
  logic [SAMPLE_BITS-1:0] right_level;
  logic [SAMPLE_BITS-1:0] left_peak;
  logic [SAMPLE_BITS-1:0] right_peak;

  modport source (output valid, output left_level, output right_level,
                  output left_peak, output right_peak, input ready);
  modport sink   (input valid, input left_level, input right_level,
                  input left_peak, input right_peak, output ready);
endinterface

`default_nettype wire

FILE: hdl/srpl_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module srpl_isqrt #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                     clk,
  input  wire logic                     init,
  input  wire logic                     step,
  input  wire logic [2*SAMPLE_BITS-1:0] radicand,
  output logic      [SAMPLE_BITS-1:0]   root
);

  localparam int unsigned RadBits = 2 * SAMPLE_BITS;
  localparam int unsigned RemBits = SAMPLE_BITS + 2;

  logic [RadBits-1:0]     rad_r;
  logic [RemBits-1:0]     rem_r;
  logic [SAMPLE_BITS-1:0] root_r;

  logic [RemBits-1:0] rem_sh;
  logic [RemBits-1:0] trial;
  logic               fits;

  assign rem_sh = {rem_r[SAMPLE_BITS-1:0], rad_r[RadBits-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (init) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (step) begin
      rad_r <= {rad_r[RadBits-3:0], 2'b00};
      if (fits) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[SAMPLE_BITS-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;

endmodule

`default_nettype wire

FILE: hdl/srpl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module srpl_dp #(
  parameter int unsigned WINDOW_LOG2 = 5,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire srpl_pkg::srpl_cmd_t             cmd,
  input  wire logic [SAMPLE_BITS-1:0]          left_sample,
  input  wire logic [SAMPLE_BITS-1:0]          right_sample,
  input  wire logic [srpl_pkg::HoldBits-1:0]   hold_reload,
  output logic      [SAMPLE_BITS-1:0]          left_level,
  output logic      [SAMPLE_BITS-1:0]          right_level,
  output logic      [SAMPLE_BITS-1:0]          left_peak,
  output logic      [SAMPLE_BITS-1:0]          right_peak
);

  localparam int unsigned Depth   = 1 << WINDOW_LOG2;
  localparam int unsigned SqBits  = 2 * SAMPLE_BITS;
  localparam int unsigned SumBits = SqBits + WINDOW_LOG2;
  localparam int unsigned HB      = srpl_pkg::HoldBits;

  logic [2*SqBits-1:0]    ring_mem [Depth];
  logic [2*SqBits-1:0]    rd_data_r;
  logic [WINDOW_LOG2-1:0] ptr_r;
  logic                   filled_r;

  logic [SAMPLE_BITS-1:0] ls_r, rs_r;
  logic [SqBits-1:0]      lsq_r, rsq_r;
  logic [SumBits-1:0]     lsum_r, rsum_r;
  logic [SAMPLE_BITS-1:0] lheld_r, rheld_r;
  logic [HB-1:0]          hold_cnt_r;
  logic [SAMPLE_BITS-1:0] llev_r, rlev_r, lpk_r, rpk_r;

  logic [SqBits-1:0]      lold, rold;
  logic [SumBits-1:0]     lsum_nxt, rsum_nxt;
  logic [SAMPLE_BITS-1:0] lroot, rroot;

  assign lold = filled_r ? rd_data_r[2*SqBits-1:SqBits] : '0;
  assign rold = filled_r ? rd_data_r[SqBits-1:0]        : '0;

  assign lsum_nxt = lsum_r - SumBits'(lold) + SumBits'(lsq_r);
  assign rsum_nxt = rsum_r - SumBits'(rold) + SumBits'(rsq_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_data_r <= ring_mem[ptr_r];
    end
    if (cmd.accum) begin
      ring_mem[ptr_r] <= {lsq_r, rsq_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ls_r <= left_sample;
      rs_r <= right_sample;
    end
    if (cmd.square) begin
      lsq_r <= {{SAMPLE_BITS{1'b0}}, ls_r} * {{SAMPLE_BITS{1'b0}}, ls_r};
      rsq_r <= {{SAMPLE_BITS{1'b0}}, rs_r} * {{SAMPLE_BITS{1'b0}}, rs_r};
    end
    if (cmd.load_out) begin
      llev_r <= lroot;
      rlev_r <= rroot;
      lpk_r  <= lheld_r;
      rpk_r  <= rheld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      filled_r   <= 1'b0;
      lsum_r     <= '0;
      rsum_r     <= '0;
      lheld_r    <= '0;
      rheld_r    <= '0;
      hold_cnt_r <= '0;
    end else begin
      if (cmd.start) begin
        if (hold_cnt_r != '0) begin
          hold_cnt_r <= hold_cnt_r - HB'(1);
        end else begin
          hold_cnt_r <= hold_reload;
          if (lheld_r != '0) begin
            lheld_r <= lheld_r - SAMPLE_BITS'(1);
          end
          if (rheld_r != '0) begin
            rheld_r <= rheld_r - SAMPLE_BITS'(1);
          end
        end
      end
      if (cmd.accum) begin
        lsum_r <= lsum_nxt;
        rsum_r <= rsum_nxt;
        ptr_r  <= ptr_r + WINDOW_LOG2'(1);
        if (ptr_r == {WINDOW_LOG2{1'b1}}) begin
          filled_r <= 1'b1;
        end
      end
      if (cmd.peak) begin
        if (lheld_r < lroot) begin
          lheld_r <= lroot;
        end
        if (rheld_r < rroot) begin
          rheld_r <= rroot;
        end
        if ((lheld_r < lroot) || (rheld_r < rroot)) begin
          hold_cnt_r <= hold_reload;
        end
      end
    end
  end

  srpl_isqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_root_l (
    .clk      (clk),
    .init     (cmd.root_init),
    .step     (cmd.root_step),
    .radicand (lsum_r[SumBits-1:WINDOW_LOG2]),
    .root     (lroot)
  );

  srpl_isqrt #(.SAMPLE_BITS(SAMPLE_BITS)) u_root_r (
    .clk      (clk),
    .init     (cmd.root_init),
    .step     (cmd.root_step),
    .radicand (rsum_r[SumBits-1:WINDOW_LOG2]),
    .root     (rroot)
  );

  assign left_level  = llev_r;
  assign right_level = rlev_r;
  assign left_peak   = lpk_r;
  assign right_peak  = rpk_r;

endmodule

`default_nettype wire

FILE: hdl/srpl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module srpl_ctrl #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output srpl_pkg::srpl_cmd_t      cmd
);

  localparam int unsigned CntBits = $clog2(SAMPLE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_PEAK,
    ST_DONE
  } state_t;

  state_t             state_r;
  logic [CntBits-1:0] cnt_r;
  logic               out_valid_r;
  logic               out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.start     = (state_r == ST_IDLE) && in_valid;
    cmd.square    = (state_r == ST_SQUARE);
    cmd.accum     = (state_r == ST_ACCUM);
    cmd.root_init = (state_r == ST_ROOT_INIT);
    cmd.root_step = (state_r == ST_ROOT);
    cmd.peak      = (state_r == ST_PEAK);
    cmd.load_out  = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE:    state_r <= ST_ACCUM;
        ST_ACCUM:     state_r <= ST_ROOT_INIT;
        ST_ROOT_INIT: begin
          cnt_r   <= '0;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (cnt_r == CntBits'(SAMPLE_BITS - 1)) begin
            state_r <= ST_PEAK;
          end else begin
            cnt_r <= cnt_r + CntBits'(1);
          end
        end
        ST_PEAK:      state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default:      state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntBits'(SAMPLE_BITS - 1))
    else $error("root step counter out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

endmodule

`default_nettype wire

FILE: hdl/stereo_rms_peak_level_meter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// in_ch     in   valid/ready            left_sample, right_sample
// out_ch    out  valid/ready            left_level, right_level, left_peak, right_peak
// apb       in   psel/penable/pready    paddr, pwdata, prdata (hold_reload at 0x0)
//
// The bit-serial square root, resolving one root bit per cycle, sets request length.
// Reset is synchronous and takes effect at once; window slots never written
// read as zero through a fill flag, so no clearing pass runs.
// A finished result holds in the output register until taken; the next
// request is accepted meanwhile and its result waits until the register frees.

module stereo_rms_peak_level_meter #(
  parameter int unsigned WINDOW_LOG2 = 5,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  srpl_in_if.sink                                    in_ch,
  srpl_out_if.source                                 out_ch,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [srpl_pkg::CfgAddrBits-1:0]      paddr,
  input  wire logic [srpl_pkg::CfgDataBits-1:0]      pwdata,
  output logic      [srpl_pkg::CfgDataBits-1:0]      prdata,
  output logic                                       pready
);

  localparam int unsigned HB = srpl_pkg::HoldBits;
  localparam int unsigned DB = srpl_pkg::CfgDataBits;

  logic [HB-1:0]        hold_reload_r;
  srpl_pkg::srpl_reg_t  reg_sel;
  srpl_pkg::srpl_cmd_t  cmd;
  logic                 in_rdy;
  logic                 out_vld;

  assign reg_sel = srpl_pkg::srpl_reg_t'(paddr[srpl_pkg::CfgAddrBits-1]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_reload_r <= srpl_pkg::HoldReset;
    end else if (psel && penable && pwrite && (reg_sel == srpl_pkg::REG_HOLD_RELOAD)) begin
      hold_reload_r <= pwdata[HB-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      srpl_pkg::REG_HOLD_RELOAD: prdata = {{(DB - HB){1'b0}}, hold_reload_r};
      default:                   prdata = '0;
    endcase
  end

  srpl_ctrl #(.SAMPLE_BITS(SAMPLE_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_rdy),
    .out_valid (out_vld),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  srpl_dp #(
    .WINDOW_LOG2 (WINDOW_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .left_sample  (in_ch.left_sample),
    .right_sample (in_ch.right_sample),
    .hold_reload  (hold_reload_r),
    .left_level   (out_ch.left_level),
    .right_level  (out_ch.right_level),
    .left_peak    (out_ch.left_peak),
    .right_peak   (out_ch.right_peak)
  );

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_vld;

  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_rdy) |=> !in_rdy)
    else $error("request accepted while another is in flight");

  a_left_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_ch.left_peak >= out_ch.left_level))
    else $error("left peak below left level");

  a_right_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_ch.right_peak >= out_ch.right_level))
    else $error("right peak below right level");

endmodule

`default_nettype wire
